// ===== sv/sepb_pkg.sv =====
`timescale 1ns / 1ps
package sepb_pkg;

    localparam int MAX_STATES        = 8;
    localparam int MAX_POINTS_FIRST  = 256;
    localparam int MAX_POINTS_SECOND = 256;

    localparam int ST_W   = $clog2(MAX_STATES);
    localparam int PF_W   = $clog2(MAX_POINTS_FIRST);
    localparam int PS_W   = $clog2(MAX_POINTS_SECOND);
    localparam int SPA_W  = PF_W + PS_W;
    localparam int MAT_AW = 3 + 2 * ST_W;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [3:0] TBL_ALPHA    = 4'd0;
    localparam logic [3:0] TBL_BETA     = 4'd1;
    localparam logic [3:0] TBL_START    = 4'd2;
    localparam logic [3:0] TBL_LAST_MIX = 4'd9;
    localparam logic [3:0] TBL_SPECTRUM = 4'd10;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [3:0] CFG_SCHEME  = 4'd0;
    localparam logic [3:0] CFG_PTS1    = 4'd1;
    localparam logic [3:0] CFG_PTS2    = 4'd2;
    localparam logic [3:0] CFG_INC1    = 4'd3;
    localparam logic [3:0] CFG_INC2    = 4'd4;
    localparam logic [3:0] CFG_LMASK   = 4'd5;
    localparam logic [3:0] CFG_RMASK   = 4'd6;
    localparam logic [3:0] CFG_NSTATES = 4'd7;

    typedef logic signed [47:0] val_t;
    typedef logic signed [31:0] q30_t;
    typedef logic [24:0]        count_t;

    // free periods of the scheme
    function automatic logic [2:0] period_count(input logic [2:0] sel);
        logic [2:0] r;
        case (sel)
            3'd0:    r = 3'd1;
            3'd1:    r = 3'd2;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd3;
            3'd5:    r = 3'd3;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic is_two_d(input logic [2:0] sel);
        return sel >= 3'd3;
    endfunction

    // 2-bit signed weights per period, period 0 in the low bits
    function automatic logic [7:0] coef_one(input logic [2:0] sel);
        logic [7:0] r;
        case (sel)
            3'd1:    r = 8'b00_00_01_01;
            3'd2:    r = 8'b00_00_11_01;
            3'd4:    r = 8'b00_01_00_01;
            3'd5:    r = 8'b00_00_01_01;
            3'd6:    r = 8'b01_00_00_01;
            3'd7:    r = 8'b00_00_01_01;
            default: r = 8'b00_00_00_01;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] coef_two(input logic [2:0] sel);
        logic [7:0] r;
        case (sel)
            3'd3:    r = 8'b00_00_01_00;
            3'd4:    r = 8'b00_00_01_00;
            3'd5:    r = 8'b00_01_00_00;
            3'd6:    r = 8'b00_01_01_00;
            3'd7:    r = 8'b01_01_00_00;
            default: r = 8'b00_00_00_00;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/sepb_if.sv =====
`timescale 1ns / 1ps
interface sepb_req_if;
    import sepb_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] table_sel;
    logic [7:0] row_index;
    logic [7:0] col_index;
    val_t       value_real;
    val_t       value_imag;
    modport source (output valid, mode, table_sel, row_index, col_index, value_real,
                    value_imag, input ready);
    modport sink (input valid, mode, table_sel, row_index, col_index, value_real,
                  value_imag, output ready);
endinterface

interface sepb_rsp_if;
    import sepb_pkg::*;
    logic       valid;
    logic       ready;
    val_t       bin_real;
    val_t       bin_imag;
    count_t     peak_count;
    logic [1:0] status;
    modport source (output valid, bin_real, bin_imag, peak_count, status, input ready);
    modport sink (input valid, bin_real, bin_imag, peak_count, status, output ready);
endinterface

interface sepb_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/spin_echo_peak_binner.sv =====
`timescale 1ns / 1ps
// channel | dir | payload                                                 | accepted when
// req     | in  | mode, table_sel, row_index, col_index, value_real/imag  | valid & ready
// rsp     | out | bin_real, bin_imag, peak_count, status                  | valid & ready
// cfg     | in  | index, data                                             | valid & ready
//
// Load items go straight to S_FIN, read items through S_READ to S_FIN; clear items write
// every spectrum bin, one bin per cycle. Run items: per combination the matrix chain on the
// shared 33x33 multiplier, the energy steps, the 1D or 2D bin steps and the spectrum
// read and write; times n^(2P) combinations. req.ready is high only in idle.
// Reset clears control and configuration; tables and spectrum hold no reset value.
// A finished result waits in the rsp register; the next item is still accepted.
module spin_echo_peak_binner (
    input logic         clk,
    input logic         rst_n,
    sepb_req_if.sink    req,
    sepb_rsp_if.source  rsp,
    sepb_cfg_if.sink    cfg
);
    import sepb_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;
    localparam logic [3:0] S_FREQ  = 4'd6;
    localparam logic [3:0] S_BIN   = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SWR   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam logic signed [47:0] Q48_MAX = 48'sd2147483647;
    localparam logic signed [47:0] I48_MIN = -48'sd2147483648;
    localparam logic signed [48:0] BIN_MAX = 49'sd140737488355327;
    localparam logic signed [48:0] BIN_MIN = -49'sd140737488355328;

    function automatic q30_t round_q30(input logic signed [65:0] v);
        logic signed [65:0] r;
        logic signed [35:0] q;
        q30_t res;
        r = v + 66'sd536870912;
        q = 36'(r >>> 30);
        if (q > 36'sd2147483647)
            res = 32'sd2147483647;
        else if (q < -36'sd2147483647)
            res = -32'sd2147483647;
        else
            res = q[31:0];
        return res;
    endfunction

    function automatic logic signed [47:0] sat_bin(input logic signed [48:0] s);
        logic signed [47:0] res;
        if (s > BIN_MAX)
            res = BIN_MAX[47:0];
        else if (s < BIN_MIN)
            res = BIN_MIN[47:0];
        else
            res = s[47:0];
        return res;
    endfunction

    // configuration
    logic [2:0]  scheme_reg, scheme_next;
    logic [8:0]  pts1_reg, pts1_next, pts2_reg, pts2_next;
    logic [31:0] inc1_reg, inc1_next, inc2_reg, inc2_next;
    logic [3:0]  lmask_reg, lmask_next, rmask_reg, rmask_next;
    logic [3:0]  nstates_reg, nstates_next;

    // sequencer
    logic [3:0]       state_reg, state_next;
    logic [2:0]       mstep_reg, mstep_next;
    logic [2:0]       estep_reg, estep_next;
    logic [2:0]       k_reg, k_next;
    logic             dim_reg, dim_next;
    logic [ST_W-1:0]  dig_reg [8];
    logic [ST_W-1:0]  dig_next [8];
    logic [SPA_W-1:0] clr_reg, clr_next;
    count_t           cnt_reg, cnt_next;
    logic             sat_reg, sat_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // datapath
    q30_t               amp_re_reg, amp_re_next, amp_im_reg, amp_im_next;
    logic signed [65:0] acc_re_reg, acc_re_next, acc_im_reg, acc_im_next;
    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a, mul_b;
    logic signed [35:0] nu1_reg, nu1_next, nu2_reg, nu2_next;
    logic [PF_W-1:0]    b1_reg, b1_next;
    logic [PS_W-1:0]    b2_reg, b2_next;
    val_t               res_re_reg, res_re_next, res_im_reg, res_im_next;
    count_t             res_cnt_reg, res_cnt_next;
    logic [1:0]         res_st_reg, res_st_next;
    val_t               out_re_reg, out_im_reg;
    count_t             out_cnt_reg;
    logic [1:0]         out_st_reg;

    // tables
    q30_t              alpha_reg [MAX_STATES];
    q30_t              beta_reg [MAX_STATES];
    logic              en_we;
    q30_t              en_wdata;
    logic [63:0]       mat_mem [2**MAT_AW];
    logic [63:0]       mat_rdata, mat_wdata;
    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr, mat_raddr;
    logic [95:0]       spec_mem [2**SPA_W];
    logic [95:0]       spec_rdata, spec_wdata;
    logic              spec_we;
    logic [SPA_W-1:0]  spec_waddr, spec_raddr;

    logic [2:0] np, last;
    logic       two;
    logic       accept;
    logic [1:0] pp;
    logic [2:0] tbl;
    logic [ST_W-1:0] mrow, mcol;

    assign np      = period_count(scheme_reg);
    assign two     = is_two_d(scheme_reg);
    assign last    = 3'((np << 1) - 3'd1);
    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.bin_real   = out_re_reg;
    assign rsp.bin_imag   = out_im_reg;
    assign rsp.peak_count = out_cnt_reg;
    assign rsp.status     = out_st_reg;

    // matrix chain address: G, then TLp/TRp per period, then D
    always_comb
    begin
        pp   = 2'(3'(mstep_reg + 3'd1) >> 1);
        tbl  = 3'd0;
        mrow = dig_reg[0];
        mcol = dig_reg[1];
        if (mstep_reg == last && mstep_reg != 3'd0)
        begin
            tbl  = 3'd1;
            mrow = dig_reg[last];
            mcol = dig_reg[3'(last - 3'd1)];
        end
        else if (mstep_reg != 3'd0)
        begin
            if (mstep_reg[0])
            begin
                tbl  = 3'(pp) + 3'd1;
                mrow = dig_reg[{pp, 1'b0}];
                mcol = dig_reg[{2'(pp - 2'd1), 1'b0}];
            end
            else
            begin
                tbl  = 3'(pp) + 3'd4;
                mrow = dig_reg[{2'(pp - 2'd1), 1'b1}];
                mcol = dig_reg[{pp, 1'b1}];
            end
        end
        mat_raddr = {tbl, mrow, mcol};
    end

    always_comb
    begin
        logic               ok;
        logic               carry;
        logic [1:0]         pe;
        logic [ST_W-1:0]    eidx;
        q30_t               eval;
        logic signed [35:0] term, nu;
        logic [7:0]         c1v, c2v;
        logic [1:0]         c1, c2;
        logic [35:0]        mag;
        logic [8:0]         pts, bn;
        logic [PF_W-1:0]    id;
        logic signed [47:0] s_re, s_im;
        logic signed [48:0] sum_re, sum_im;
        q30_t               mre, mim;

        scheme_next  = scheme_reg;
        pts1_next    = pts1_reg;
        pts2_next    = pts2_reg;
        inc1_next    = inc1_reg;
        inc2_next    = inc2_reg;
        lmask_next   = lmask_reg;
        rmask_next   = rmask_reg;
        nstates_next = nstates_reg;
        state_next   = state_reg;
        mstep_next   = mstep_reg;
        estep_next   = estep_reg;
        k_next       = k_reg;
        dim_next     = dim_reg;
        dig_next     = dig_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        amp_re_next  = amp_re_reg;
        amp_im_next  = amp_im_reg;
        acc_re_next  = acc_re_reg;
        acc_im_next  = acc_im_reg;
        nu1_next     = nu1_reg;
        nu2_next     = nu2_reg;
        b1_next      = b1_reg;
        b2_next      = b2_reg;
        res_re_next  = res_re_reg;
        res_im_next  = res_im_reg;
        res_cnt_next = res_cnt_reg;
        res_st_next  = res_st_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;

        en_we      = 1'b0;
        en_wdata   = req.value_real[31:0];
        mat_we     = 1'b0;
        mat_waddr  = {3'(req.table_sel - TBL_START), req.row_index[ST_W-1:0],
                      req.col_index[ST_W-1:0]};
        mat_wdata  = '0;
        spec_we    = 1'b0;
        spec_waddr = {b2_reg, b1_reg};
        spec_wdata = '0;
        spec_raddr = {b2_reg, b1_reg};
        mul_a      = '0;
        mul_b      = '0;

        ok    = 1'b0;
        carry = 1'b1;
        pe    = estep_reg[2:1];
        eidx  = dig_reg[estep_reg];
        eval  = q30_t'(0);
        term  = '0;
        c1v   = coef_one(scheme_reg);
        c2v   = coef_two(scheme_reg);
        c1    = c1v[{pe, 1'b0} +: 2];
        c2    = c2v[{pe, 1'b0} +: 2];
        nu    = dim_reg ? nu2_reg : nu1_reg;
        mag   = (nu < 0) ? 36'(-nu) : 36'(nu);
        pts   = dim_reg ? pts2_reg : pts1_reg;
        id    = prod_reg[32 +: PF_W];
        bn    = ((nu > 0) && (id != '0)) ? 9'(pts - 9'(id)) : 9'(id);
        s_re  = spec_rdata[95:48];
        s_im  = spec_rdata[47:0];
        sum_re = 49'(s_re) + 49'(amp_re_reg);
        sum_im = 49'(s_im) + 49'(amp_im_reg);
        mre   = mat_rdata[63:32];
        mim   = mat_rdata[31:0];

        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SCHEME:  scheme_next  = cfg.data[2:0];
                CFG_PTS1:    pts1_next    = cfg.data[8:0];
                CFG_PTS2:    pts2_next    = cfg.data[8:0];
                CFG_INC1:    inc1_next    = cfg.data;
                CFG_INC2:    inc2_next    = cfg.data;
                CFG_LMASK:   lmask_next   = cfg.data[3:0];
                CFG_RMASK:   rmask_next   = cfg.data[3:0];
                CFG_NSTATES: nstates_next = cfg.data[3:0];
                default: ;
            endcase
        end

        if (state_reg == S_IDLE)
            spec_raddr = {req.col_index[PS_W-1:0], req.row_index[PF_W-1:0]};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_re_next  = '0;
                    res_im_next  = '0;
                    res_cnt_next = '0;
                    res_st_next  = ST_OK;
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            state_next = S_FIN;
                            if (req.table_sel <= TBL_BETA)
                            begin
                                ok    = int'(req.row_index) < MAX_STATES;
                                en_we = ok;
                                if (req.value_real > Q48_MAX)
                                    en_wdata = Q48_MAX[31:0];
                                else if (req.value_real < I48_MIN)
                                    en_wdata = I48_MIN[31:0];
                            end
                            else if (req.table_sel == TBL_SPECTRUM)
                            begin
                                ok = int'(req.row_index) < MAX_POINTS_FIRST &&
                                     int'(req.col_index) < MAX_POINTS_SECOND;
                                spec_we    = ok;
                                spec_waddr = {req.col_index[PS_W-1:0],
                                              req.row_index[PF_W-1:0]};
                                spec_wdata = {req.value_real, req.value_imag};
                            end
                            else
                            begin
                                ok = req.table_sel <= TBL_LAST_MIX &&
                                     int'(req.row_index) < MAX_STATES &&
                                     int'(req.col_index) < MAX_STATES;
                                mat_we = ok;
                                mat_wdata[63:32] = req.value_real[31:0];
                                mat_wdata[31:0]  = req.value_imag[31:0];
                                if (req.value_real > Q48_MAX)
                                    mat_wdata[63:32] = Q48_MAX[31:0];
                                else if (req.value_real < -Q48_MAX)
                                    mat_wdata[63:32] = 32'(-Q48_MAX);
                                if (req.value_imag > Q48_MAX)
                                    mat_wdata[31:0] = Q48_MAX[31:0];
                                else if (req.value_imag < -Q48_MAX)
                                    mat_wdata[31:0] = 32'(-Q48_MAX);
                            end
                            if (!ok)
                                res_st_next = ST_RANGE;
                        end
                        MODE_RUN:
                        begin
                            if (nstates_reg == 4'd0 || int'(nstates_reg) > MAX_STATES ||
                                pts1_reg == 9'd0 || int'(pts1_reg) > MAX_POINTS_FIRST ||
                                (two && (pts2_reg == 9'd0 ||
                                         int'(pts2_reg) > MAX_POINTS_SECOND)))
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                for (int i = 0; i < 8; i++)
                                    dig_next[i] = '0;
                                mstep_next = '0;
                                cnt_next   = '0;
                                sat_next   = 1'b0;
                                state_next = S_FETCH;
                            end
                        end
                        MODE_READ:  state_next = S_READ;
                        MODE_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                res_re_next = s_re;
                res_im_next = s_im;
                state_next  = S_FIN;
            end
            S_CLEAR:
            begin
                spec_we    = 1'b1;
                spec_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = S_FIN;
            end
            S_FETCH:
            begin
                k_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = 33'(amp_re_reg);
                        mul_b = 33'(mre);
                    end
                    3'd1:
                    begin
                        mul_a = 33'(amp_im_reg);
                        mul_b = 33'(mim);
                    end
                    3'd2:
                    begin
                        mul_a = 33'(amp_re_reg);
                        mul_b = 33'(mim);
                    end
                    3'd3:
                    begin
                        mul_a = 33'(amp_im_reg);
                        mul_b = 33'(mre);
                    end
                    default: ;
                endcase
                // accumulate the product issued in the previous cycle
                case (k_reg)
                    3'd1: acc_re_next = prod_reg;
                    3'd2: acc_re_next = acc_re_reg - prod_reg;
                    3'd3: acc_im_next = prod_reg;
                    3'd4: acc_im_next = acc_im_reg + prod_reg;
                    default: ;
                endcase
                k_next = k_reg + 3'd1;
                if (mstep_reg == 3'd0)
                begin
                    amp_re_next = mre;
                    amp_im_next = mim;
                    mstep_next  = 3'd1;
                    state_next  = S_FETCH;
                end
                else if (k_reg == 3'd4)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                amp_re_next = round_q30(acc_re_reg);
                amp_im_next = round_q30(acc_im_reg);
                if (mstep_reg == last)
                begin
                    estep_next = '0;
                    nu1_next   = '0;
                    nu2_next   = '0;
                    state_next = S_FREQ;
                end
                else
                begin
                    mstep_next = mstep_reg + 3'd1;
                    state_next = S_FETCH;
                end
            end
            S_FREQ:
            begin
                // even step: left energy of period, odd step: minus right energy
                if (!estep_reg[0])
                begin
                    eval = lmask_reg[pe] ? alpha_reg[eidx] : beta_reg[eidx];
                    term = 36'(eval);
                end
                else
                begin
                    eval = rmask_reg[pe] ? alpha_reg[eidx] : beta_reg[eidx];
                    term = -36'(eval);
                end
                if (c1 == 2'b01)
                    nu1_next = nu1_reg + term;
                else if (c1 == 2'b11)
                    nu1_next = nu1_reg - term;
                if (c2 == 2'b01)
                    nu2_next = nu2_reg + term;
                else if (c2 == 2'b11)
                    nu2_next = nu2_reg - term;
                estep_next = estep_reg + 3'd1;
                if (estep_reg == last)
                begin
                    k_next     = '0;
                    dim_next   = 1'b0;
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                k_next = k_reg + 3'd1;
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = {1'b0, mag[31:0]};
                        mul_b = {1'b0, (dim_reg ? inc2_reg : inc1_reg)};
                    end
                    3'd1:
                    begin
                        mul_a = {1'b0, prod_reg[31:0]};
                        mul_b = 33'(pts);
                    end
                    default:
                    begin
                        k_next = '0;
                        if (!dim_reg)
                        begin
                            b1_next = bn[PF_W-1:0];
                            b2_next = '0;
                            if (two)
                                dim_next = 1'b1;
                            else
                                state_next = S_SRD;
                        end
                        else
                        begin
                            b2_next    = bn[PS_W-1:0];
                            state_next = S_SRD;
                        end
                    end
                endcase
            end
            S_SRD: state_next = S_SWR;
            S_SWR:
            begin
                spec_we    = 1'b1;
                spec_wdata = {sat_bin(sum_re), sat_bin(sum_im)};
                if (sum_re > BIN_MAX || sum_re < BIN_MIN ||
                    sum_im > BIN_MAX || sum_im < BIN_MIN)
                    sat_next = 1'b1;
                if (cnt_reg != '1)
                    cnt_next = cnt_reg + 1'b1;
                // advance the mixed-radix state counter, a0 fastest
                for (int i = 0; i < 8; i++)
                begin
                    if (i <= int'(last) && carry)
                    begin
                        if (dig_reg[i] == ST_W'(nstates_reg - 4'd1))
                            dig_next[i] = '0;
                        else
                        begin
                            dig_next[i] = dig_reg[i] + 1'b1;
                            carry = 1'b0;
                        end
                    end
                end
                mstep_next = '0;
                if (carry)
                begin
                    res_cnt_next = cnt_next;
                    res_st_next  = sat_next ? ST_SAT : ST_OK;
                    state_next   = S_FIN;
                end
                else
                    state_next = S_FETCH;
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg    <= '0;
            pts1_reg      <= 9'd1;
            pts2_reg      <= 9'd1;
            inc1_reg      <= '0;
            inc2_reg      <= '0;
            lmask_reg     <= '0;
            rmask_reg     <= '0;
            nstates_reg   <= 4'd1;
            state_reg     <= S_IDLE;
            mstep_reg     <= '0;
            estep_reg     <= '0;
            k_reg         <= '0;
            dim_reg       <= 1'b0;
            for (int i = 0; i < 8; i++)
                dig_reg[i] <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            scheme_reg    <= scheme_next;
            pts1_reg      <= pts1_next;
            pts2_reg      <= pts2_next;
            inc1_reg      <= inc1_next;
            inc2_reg      <= inc2_next;
            lmask_reg     <= lmask_next;
            rmask_reg     <= rmask_next;
            nstates_reg   <= nstates_next;
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            estep_reg     <= estep_next;
            k_reg         <= k_next;
            dim_reg       <= dim_next;
            dig_reg       <= dig_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amp_re_reg  <= amp_re_next;
        amp_im_reg  <= amp_im_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        prod_reg    <= mul_a * mul_b;
        nu1_reg     <= nu1_next;
        nu2_reg     <= nu2_next;
        b1_reg      <= b1_next;
        b2_reg      <= b2_next;
        res_re_reg  <= res_re_next;
        res_im_reg  <= res_im_next;
        res_cnt_reg <= res_cnt_next;
        res_st_reg  <= res_st_next;
        if (state_reg == S_FIN && (!rsp_valid_reg || rsp.ready))
        begin
            out_re_reg  <= res_re_reg;
            out_im_reg  <= res_im_reg;
            out_cnt_reg <= res_cnt_reg;
            out_st_reg  <= res_st_reg;
        end
        if (en_we)
        begin
            if (req.table_sel == TBL_ALPHA)
                alpha_reg[req.row_index[ST_W-1:0]] <= en_wdata;
            else
                beta_reg[req.row_index[ST_W-1:0]] <= en_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_waddr] <= mat_wdata;
        mat_rdata <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (spec_we)
            spec_mem[spec_waddr] <= spec_wdata;
        spec_rdata <= spec_mem[spec_raddr];
    end

endmodule

// ===== sv/sepb_check.sv =====
`timescale 1ns / 1ps
module sepb_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input sepb_pkg::val_t       bin_real,
    input sepb_pkg::val_t       bin_imag,
    input sepb_pkg::count_t     peak_count,
    input logic [1:0]           status
);
    import sepb_pkg::*;

    // no new item is accepted in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("input taken on consecutive cycles");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_real) && $stable(bin_imag)
            && $stable(peak_count) && $stable(status))
        else $error("stalled result changed");

    a_bins_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (bin_real != '0 || bin_imag != '0) |->
            peak_count == '0 && status == ST_OK)
        else $error("bin data on a non-read result");

    a_count_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && peak_count != '0 |-> status == ST_OK || status == ST_SAT)
        else $error("peak count with range status");

endmodule

bind spin_echo_peak_binner sepb_check u_sepb_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .bin_real   (rsp.bin_real),
    .bin_imag   (rsp.bin_imag),
    .peak_count (rsp.peak_count),
    .status     (rsp.status)
);
